### design/ccp_pkg.sv
// Shared types, mode codes and matrix coefficients for the cataract pixel color pipeline.
package ccp_pkg;

  typedef logic [2:0] mode_t;
  typedef logic [7:0] chan_t;
  typedef logic signed [17:0] coef_t;
  typedef logic signed [26:0] prod_t;
  typedef logic signed [28:0] acc_t;

  localparam mode_t MODE_PASS = 3'd0;
  localparam mode_t MODE_FULL = 3'd1;
  localparam mode_t MODE_GB_A = 3'd2;
  localparam mode_t MODE_GB_B = 3'd3;
  localparam mode_t MODE_VEIL = 3'd4;

  // Q16 color-deficiency matrix, row major
  localparam coef_t COEF [3][3] = '{
    '{ 18'sd82282, -18'sd5030,  -18'sd11716 },
    '{ -18'sd5139, 18'sd61001,  18'sd9673   },
    '{ 18'sd310,   18'sd45309,  18'sd19916  }
  };

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } pixel_t;

  function automatic logic mode_is_gb(input mode_t m);
    return (m == MODE_GB_A) || (m == MODE_GB_B) || (m == MODE_VEIL);
  endfunction

endpackage

### design/ccp_front.sv
// Stage 1: floater red lift and dark veil scaling.
module ccp_front (
  input  logic            clk,
  input  logic            rst,
  input  ccp_pkg::mode_t  view_mode,
  input  logic            valid_in,
  output logic            ready,
  input  logic            stall_down,
  input  ccp_pkg::chan_t  red,
  input  ccp_pkg::chan_t  green,
  input  ccp_pkg::chan_t  blue,
  input  ccp_pkg::chan_t  veil_red,
  input  ccp_pkg::chan_t  veil_green,
  input  ccp_pkg::chan_t  veil_blue,
  input  logic            floater_on,
  input  ccp_pkg::chan_t  floater_level,
  output logic            valid,
  output ccp_pkg::pixel_t pix
);

  ccp_pkg::chan_t  red_lift;
  logic [15:0]     prod_r, prod_g, prod_b;
  ccp_pkg::pixel_t pix_next;

  assign ready = !valid || !stall_down;

  always_comb begin
    red_lift = (floater_on && (floater_level > red)) ? floater_level : red;
    prod_r = 16'(red_lift) * 16'(veil_red);
    prod_g = 16'(green) * 16'(veil_green);
    prod_b = 16'(blue) * 16'(veil_blue);
    if (view_mode == ccp_pkg::MODE_VEIL) begin
      pix_next.red   = prod_r[15:8];
      pix_next.green = prod_g[15:8];
      pix_next.blue  = prod_b[15:8];
    end else begin
      pix_next.red   = red_lift;
      pix_next.green = green;
      pix_next.blue  = blue;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && valid_in) begin
      pix <= pix_next;
    end
  end

endmodule

### design/ccp_matrix_mul.sv
// Stage 2: the nine coefficient-times-channel products.
module ccp_matrix_mul (
  input  logic            clk,
  input  logic            rst,
  input  logic            valid_in,
  output logic            ready,
  input  logic            stall_down,
  input  ccp_pkg::pixel_t pix_in,
  output logic            valid,
  output ccp_pkg::pixel_t pix,
  output ccp_pkg::prod_t  prod [3][3]
);

  logic signed [8:0] chan [3];

  assign ready = !valid || !stall_down;
  assign chan[0] = $signed({1'b0, pix_in.red});
  assign chan[1] = $signed({1'b0, pix_in.green});
  assign chan[2] = $signed({1'b0, pix_in.blue});

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && valid_in) begin
      pix <= pix_in;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod[i][j] <= ccp_pkg::COEF[i][j] * chan[j];
        end
      end
    end
  end

endmodule

### design/ccp_sat.sv
// Stage 3: row sums, truncation, saturation and mode select.
module ccp_sat (
  input  logic            clk,
  input  logic            rst,
  input  ccp_pkg::mode_t  view_mode,
  input  logic            valid_in,
  output logic            ready,
  input  logic            stall_down,
  input  ccp_pkg::pixel_t pix_in,
  input  ccp_pkg::prod_t  prod [3][3],
  output logic            valid,
  output ccp_pkg::pixel_t pix
);

  ccp_pkg::acc_t   acc [3];
  ccp_pkg::chan_t  sat [3];
  ccp_pkg::pixel_t pix_next;

  assign ready = !valid || !stall_down;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = ccp_pkg::acc_t'(prod[i][0]) + ccp_pkg::acc_t'(prod[i][1])
             + ccp_pkg::acc_t'(prod[i][2]);
      if (acc[i][28] || (acc[i] == '0)) begin
        sat[i] = '0;
      end else if (acc[i][27:24] != '0) begin
        sat[i] = 8'hFF;
      end else begin
        sat[i] = acc[i][23:16];
      end
    end
    if (view_mode == ccp_pkg::MODE_FULL) begin
      pix_next.red   = sat[0];
      pix_next.green = sat[1];
      pix_next.blue  = sat[2];
    end else if (ccp_pkg::mode_is_gb(view_mode)) begin
      pix_next.red   = '0;
      pix_next.green = sat[1];
      pix_next.blue  = sat[2];
    end else begin
      pix_next = pix_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && valid_in) begin
      pix <= pix_next;
    end
  end

endmodule

### design/cataract_pixel_color_pipeline.sv
// Top level of the cataract pixel color pipeline.
// Input channel: in_valid / in_stall with one pixel, its veil factors and
// floater coverage as separate ports; a request is taken on a rising edge
// with in_valid high and in_stall low.
// Output channel: out_valid / out_stall with out_red, out_green, out_blue.
// Configuration: cfg_we with cfg_data writes view_mode; write only while idle.
// Pipeline: three register stages (floater and veil multiply, nine matrix
// products, row sums with saturation), which a pixel passes in order to reach
// out_valid; throughput is one pixel per clock while out_stall is low.
// Each stage advances when it is empty or the next one takes its data, so a
// stall at the output backs up stage by stage and in_stall rises once all
// three stages are full; nothing is lost or repeated.
// Reset (rst, synchronous) empties the pipeline and sets view_mode to 0
// (pass-through).
module cataract_pixel_color_pipeline (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [2:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  input  logic [7:0] veil_red,
  input  logic [7:0] veil_green,
  input  logic [7:0] veil_blue,
  input  logic       floater_on,
  input  logic [7:0] floater_level,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue
);

  ccp_pkg::mode_t  view_mode;
  logic            s1_valid, s1_ready, s2_valid, s2_ready, s3_ready;
  ccp_pkg::pixel_t s1_pix, s2_pix, s3_pix;
  ccp_pkg::prod_t  s2_prod [3][3];

  always_ff @(posedge clk) begin
    if (rst) begin
      view_mode <= ccp_pkg::MODE_PASS;
    end else if (cfg_we) begin
      view_mode <= cfg_data;
    end
  end

  assign in_stall = !s1_ready;

  ccp_front u_front (
    .clk           (clk),
    .rst           (rst),
    .view_mode     (view_mode),
    .valid_in      (in_valid),
    .ready         (s1_ready),
    .stall_down    (!s2_ready),
    .red           (red),
    .green         (green),
    .blue          (blue),
    .veil_red      (veil_red),
    .veil_green    (veil_green),
    .veil_blue     (veil_blue),
    .floater_on    (floater_on),
    .floater_level (floater_level),
    .valid         (s1_valid),
    .pix           (s1_pix)
  );

  ccp_matrix_mul u_mul (
    .clk        (clk),
    .rst        (rst),
    .valid_in   (s1_valid),
    .ready      (s2_ready),
    .stall_down (!s3_ready),
    .pix_in     (s1_pix),
    .valid      (s2_valid),
    .pix        (s2_pix),
    .prod       (s2_prod)
  );

  ccp_sat u_sat (
    .clk        (clk),
    .rst        (rst),
    .view_mode  (view_mode),
    .valid_in   (s2_valid),
    .ready      (s3_ready),
    .stall_down (out_stall),
    .pix_in     (s2_pix),
    .prod       (s2_prod),
    .valid      (out_valid),
    .pix        (s3_pix)
  );

  assign out_red   = s3_pix.red;
  assign out_green = s3_pix.green;
  assign out_blue  = s3_pix.blue;

endmodule

### tb/ccp_pixel_checker.sv
// Request/result monitor, pixel predictor and scoreboard for the cataract pixel pipeline.
`timescale 1ns / 100ps

module ccp_pixel_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [2:0] cfg_data,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  input  logic [7:0] veil_red,
  input  logic [7:0] veil_green,
  input  logic [7:0] veil_blue,
  input  logic       floater_on,
  input  logic [7:0] floater_level,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_red,
  input  logic [7:0] out_green,
  input  logic [7:0] out_blue,
  output int         fail_count,
  output int         outstanding,
  output int         results_seen
);

  ccp_pkg::mode_t  view_mode;
  ccp_pkg::pixel_t expected_px_q[$];

  // one row of the Q16 deficiency matrix, clamped to 0..255
  function automatic ccp_pkg::chan_t mix_row(input int row, input longint r,
                                             input longint g, input longint b);
    longint acc;
    case (row)
      0:       acc = 82282 * r - 5030 * g - 11716 * b;
      1:       acc = -5139 * r + 61001 * g + 9673 * b;
      default: acc = 310 * r + 45309 * g + 19916 * b;
    endcase
    if (acc <= 0) return 8'd0;
    acc = acc >>> 16;
    return (acc > 255) ? 8'd255 : ccp_pkg::chan_t'(acc);
  endfunction

  function automatic ccp_pkg::pixel_t predict_pixel(
    input ccp_pkg::mode_t m, input ccp_pkg::chan_t r_in, input ccp_pkg::chan_t g_in,
    input ccp_pkg::chan_t b_in, input ccp_pkg::chan_t vr, input ccp_pkg::chan_t vg,
    input ccp_pkg::chan_t vb, input logic fl_on, input ccp_pkg::chan_t fl_lvl);
    int unsigned     r, g, b;
    ccp_pkg::pixel_t px;
    r = r_in;
    g = g_in;
    b = b_in;
    if (fl_on && fl_lvl > r) r = fl_lvl;
    if (m == ccp_pkg::MODE_VEIL) begin
      r = (r * vr) >> 8;
      g = (g * vg) >> 8;
      b = (b * vb) >> 8;
    end
    case (m) inside
      ccp_pkg::MODE_FULL: begin
        px.red   = mix_row(0, r, g, b);
        px.green = mix_row(1, r, g, b);
        px.blue  = mix_row(2, r, g, b);
      end
      ccp_pkg::MODE_GB_A, ccp_pkg::MODE_GB_B, ccp_pkg::MODE_VEIL: begin
        px.red   = 8'd0;
        px.green = mix_row(1, r, g, b);
        px.blue  = mix_row(2, r, g, b);
      end
      default: begin
        px.red   = ccp_pkg::chan_t'(r);
        px.green = ccp_pkg::chan_t'(g);
        px.blue  = ccp_pkg::chan_t'(b);
      end
    endcase
    return px;
  endfunction

  task automatic compare_chan(input string name, input ccp_pkg::chan_t want,
                              input ccp_pkg::chan_t got, inout int errs);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    ccp_pkg::pixel_t want;
    int              errs;
    errs = 0;
    if (rst) begin
      view_mode    <= ccp_pkg::MODE_PASS;
      expected_px_q.delete();
      outstanding  <= 0;
      fail_count   <= 0;
      results_seen <= 0;
    end else begin
      if (cfg_we) view_mode <= cfg_data;
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        if (expected_px_q.size() == 0) begin
          $error("result with no pending request: %0d %0d %0d", out_red, out_green, out_blue);
          errs++;
        end else begin
          want = expected_px_q.pop_front();
          compare_chan("out_red", want.red, out_red, errs);
          compare_chan("out_green", want.green, out_green, errs);
          compare_chan("out_blue", want.blue, out_blue, errs);
        end
      end
      if (in_valid && !in_stall)
        expected_px_q.push_back(predict_pixel(view_mode, red, green, blue, veil_red,
                                              veil_green, veil_blue, floater_on,
                                              floater_level));
      fail_count  <= fail_count + errs;
      outstanding <= expected_px_q.size();
    end
  end

endmodule

### tb/testbench.sv
// Top of the cataract pixel pipeline testbench: clock, reset, pixel traffic and verdict.
`timescale 1ns / 100ps

module testbench;

  localparam ccp_pkg::mode_t MODE_UNDEF_FIRST = 3'd5;
  localparam ccp_pkg::mode_t MODE_UNDEF_LAST  = 3'd7;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_we;
  logic [2:0] cfg_data;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] red, green, blue;
  logic [7:0] veil_red, veil_green, veil_blue;
  logic       floater_on;
  logic [7:0] floater_level;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_red, out_green, out_blue;

  int failures;
  int outstanding;
  int results_seen;
  int pixels_sent;
  int mode_writes;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  cataract_pixel_color_pipeline u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .red           (red),
    .green         (green),
    .blue          (blue),
    .veil_red      (veil_red),
    .veil_green    (veil_green),
    .veil_blue     (veil_blue),
    .floater_on    (floater_on),
    .floater_level (floater_level),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue)
  );

  ccp_pixel_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .red           (red),
    .green         (green),
    .blue          (blue),
    .veil_red      (veil_red),
    .veil_green    (veil_green),
    .veil_blue     (veil_blue),
    .floater_on    (floater_on),
    .floater_level (floater_level),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .fail_count    (failures),
    .outstanding   (outstanding),
    .results_seen  (results_seen)
  );

  function automatic ccp_pkg::chan_t pick_chan();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 8'd0;
    if (sel == 1) return 8'd255;
    return ccp_pkg::chan_t'($urandom_range(0, 255));
  endfunction

  function automatic int pick_gap(input bit quiet);
    int unsigned sel;
    if (quiet) return 0;
    sel = $urandom_range(0, 99);
    if (sel < 55) return 0;
    if (sel < 88) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic send_pixel(input ccp_pkg::chan_t r, input ccp_pkg::chan_t g,
                            input ccp_pkg::chan_t b, input ccp_pkg::chan_t vr,
                            input ccp_pkg::chan_t vg, input ccp_pkg::chan_t vb,
                            input logic fon, input ccp_pkg::chan_t flv, input int gap);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    red           <= r;
    green         <= g;
    blue          <= b;
    veil_red      <= vr;
    veil_green    <= vg;
    veil_blue     <= vb;
    floater_on    <= fon;
    floater_level <= flv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pixels_sent++;
  endtask

  task automatic send_random(input bit quiet);
    ccp_pkg::chan_t flv;
    flv = ($urandom_range(0, 9) == 0) ? ccp_pkg::chan_t'($urandom_range(200, 255))
                                      : ccp_pkg::chan_t'($urandom_range(0, 199));
    send_pixel(pick_chan(), pick_chan(), pick_chan(), pick_chan(), pick_chan(), pick_chan(),
               logic'($urandom_range(0, 1)), flv, pick_gap(quiet));
  endtask

  // stop requesting and wait for every predicted pixel to come back
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic set_mode(input ccp_pkg::mode_t m);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= m;
    @(negedge clk);
    cfg_we   <= 1'b0;
    mode_writes++;
  endtask

  // output stall: short bursts, long holds and quiet stretches
  initial begin
    int unsigned sel;
    int          len;
    logic        level;
    out_stall = 1'b0;
    forever begin
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        level = 1'b0;
        len   = $urandom_range(1, 4);
      end else if (sel < 75) begin
        level = 1'b1;
        len   = $urandom_range(1, 3);
      end else if (sel < 90) begin
        level = 1'b0;
        len   = $urandom_range(20, 80);
      end else begin
        level = 1'b1;
        len   = $urandom_range(10, 40);
      end
      repeat (len) @(negedge clk) out_stall <= level;
    end
  end

  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    ccp_pkg::mode_t next_mode;
    bit             quiet;
    int             pause_at;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_data      = ccp_pkg::MODE_PASS;
    in_valid      = 1'b0;
    red           = '0;
    green         = '0;
    blue          = '0;
    veil_red      = '0;
    veil_green    = '0;
    veil_blue     = '0;
    floater_on    = 1'b0;
    floater_level = '0;
    pixels_sent   = 0;
    mode_writes   = 0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // every mode code, undefined ones included, with zero, full-scale and mixed pixels
    for (int m = ccp_pkg::MODE_PASS; m <= MODE_UNDEF_LAST; m++) begin
      set_mode(ccp_pkg::mode_t'(m));
      send_pixel(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 0);
      send_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 8'd255, 0);
      send_pixel(8'd0, 8'd255, 8'd128, 8'd255, 8'd0, 8'd128, 1'b1, 8'd199, 1);
    end

    for (int p = 0; p < 12; p++) begin
      if ($urandom_range(0, 3) == 0)
        next_mode = ccp_pkg::mode_t'($urandom_range(MODE_UNDEF_FIRST, MODE_UNDEF_LAST));
      else
        next_mode = ccp_pkg::mode_t'($urandom_range(ccp_pkg::MODE_PASS, ccp_pkg::MODE_VEIL));
      set_mode(next_mode);
      quiet    = ($urandom_range(0, 3) == 0);
      pause_at = (p == 0 || $urandom_range(0, 2) == 0) ? $urandom_range(5, 28) : -1;
      for (int i = 0; i < 34; i++) begin
        if (i == pause_at) drain();
        send_random(quiet);
      end
    end

    drain();
    repeat (8) @(negedge clk);
    $display("Covered %0d pixels and %0d results over %0d mode writes, codes 0 to 7.",
             pixels_sent, results_seen, mode_writes);
    $display("Floater, veil and channel extremes ran under random gaps and output stalls.");
    if (failures == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

### filelist.f
design/ccp_pkg.sv
design/ccp_front.sv
design/ccp_matrix_mul.sv
design/ccp_sat.sv
design/cataract_pixel_color_pipeline.sv
tb/ccp_pixel_checker.sv
tb/testbench.sv
